### hdl/lkt_pkg.sv
// Package: item types, register constants and cell control for the LRU key tracker.
`default_nettype none

package lkt_pkg;

	localparam int KEY_W = 32;
	localparam int CFG_W = 5;

	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic signed [KEY_W-1:0] key;
	} lkt_in_t;

	typedef struct packed {
		logic                    hit;
		logic                    evicted_valid;
		logic signed [KEY_W-1:0] evicted_key;
		logic                    entry_valid;
		logic signed [KEY_W-1:0] entry_key;
		logic                    last;
	} lkt_out_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_TAKE_PREV,
		OP_TAKE_NEXT,
		OP_TAKE_WRAP
	} lkt_op_t;

	typedef struct packed {
		lkt_op_t op;
		logic    occupied;
	} lkt_cell_ctl_t;

endpackage

`default_nettype wire

### hdl/lkt_cell.sv
// One position of the recency chain: holds a key, compares it, takes a neighbor's key.
`default_nettype none

module lkt_cell (
	input  wire                      clk,
	input  lkt_pkg::lkt_cell_ctl_t   ctl,
	input  wire [lkt_pkg::KEY_W-1:0] prev_key,
	input  wire [lkt_pkg::KEY_W-1:0] next_key,
	input  wire [lkt_pkg::KEY_W-1:0] wrap_key,
	input  wire [lkt_pkg::KEY_W-1:0] probe,
	output logic [lkt_pkg::KEY_W-1:0] key,
	output logic                      match
);

	import lkt_pkg::*;

	logic [KEY_W-1:0] key_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_TAKE_PREV: key_q <= prev_key;
			OP_TAKE_NEXT: key_q <= next_key;
			OP_TAKE_WRAP: key_q <= wrap_key;
			default:      key_q <= key_q;
		endcase
	end

	assign key   = key_q;
	// only a position inside the occupied part of the list can hit
	assign match = ctl.occupied && (key_q == probe);

endmodule

`default_nettype wire

### hdl/lru_key_tracker.sv
// Top level of the LRU key tracker: occupancy, dump sequencing and the cell chain.
`default_nettype none

// Channel  Handshake          Payload          Moves
// req      req_valid/stall    lkt_in_t         access or dump item in
// rsp      rsp_valid/stall    lkt_out_t        one result item out
// cfg      cfg_valid/ready    cfg_data[4:0]    capacity_in_use write
//
// For an access item all cells compare the key in parallel, the chain shifts
// once and the result lands in the output register.
// A dump item reads cell 0 out and rotates the occupied part of the chain one
// place per cycle unless rsp stalls; one result per entry (one if empty).
// Reset clears occupancy, the dump sequencer and the output valid; capacity
// returns to 16. Cell keys are not reset.
// While rsp is stalled with a result held, req is stalled and the dump pauses.

module lru_key_tracker #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  lkt_pkg::lkt_in_t             req,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output lkt_pkg::lkt_out_t            rsp,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [lkt_pkg::CFG_W-1:0]     cfg_data
);

	import lkt_pkg::*;

	// occupancy counts up to MAX_ENTRIES inclusive
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t             state_q;
	logic [OCC_W-1:0]   occ_q;
	logic [OCC_W-1:0]   remain_q;
	logic [CFG_W-1:0]   cap_q;
	logic               rsp_valid_q;
	lkt_out_t           rsp_q;

	logic [KEY_W-1:0]    cell_key [MAX_ENTRIES];
	lkt_cell_ctl_t       cell_ctl [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match;

	logic               load_ok;
	logic               take;
	logic               do_access;
	logic               do_dump;
	logic               dump_step;
	logic               rotate;
	logic               hit;
	logic               full;
	logic [OCC_W-1:0]   hit_idx;
	logic [OCC_W-1:0]   last_idx;
	logic [OCC_W-1:0]   pos;
	logic [KEY_W-1:0]   tail_key;
	logic [CMP_W-1:0]   cap_eff;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   max_ext;
	lkt_out_t           rsp_d;
	logic               emit;

	// --- handshakes -------------------------------------------------------
	// the output register can take a new result when empty or being drained
	assign load_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !load_ok;
	assign take      = req_valid && !req_stall;
	assign do_access = take && (req.kind == KIND_ACCESS);
	assign do_dump   = take && (req.kind == KIND_DUMP);
	assign dump_step = (state_q == ST_DUMP) && load_ok;
	// rotate the occupied part once per dumped entry; occ rotations restore order
	assign rotate    = (do_dump && (occ_q != '0)) || dump_step;
	assign cfg_ready = 1'b1;

	// --- capacity clamp: zero acts as one, above the chain length as the length
	assign cap_ext = CMP_W'(cap_q);
	assign max_ext = CMP_W'(MAX_ENTRIES);
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > max_ext) begin
			cap_eff = max_ext;
		end else begin
			cap_eff = cap_ext;
		end
	end
	assign full = CMP_W'(occ_q) >= cap_eff;

	// --- match encode and tail read ---------------------------------------
	// keys in the list are distinct, so at most one match bit is set
	assign last_idx = occ_q - OCC_W'(1);
	assign hit      = |match;

	always_comb begin
		hit_idx  = '0;
		tail_key = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | OCC_W'(i);
			end
			if (last_idx == OCC_W'(i)) begin
				tail_key = tail_key | cell_key[i];
			end
		end
	end

	// last position that takes its left neighbor on an access:
	// the hit position, or the tail on a full miss, or one past it otherwise
	always_comb begin
		if (hit) begin
			pos = hit_idx;
		end else if (full) begin
			pos = last_idx;
		end else begin
			pos = occ_q;
		end
	end

	// --- cell chain -------------------------------------------------------
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [KEY_W-1:0] prev_k;
		logic [KEY_W-1:0] next_k;

		if (i == 0) begin : g_head
			assign prev_k = req.key;
		end else begin : g_body
			assign prev_k = cell_key[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_end
			assign next_k = cell_key[i];
		end else begin : g_mid
			assign next_k = cell_key[i+1];
		end

		always_comb begin
			cell_ctl[i].occupied = OCC_W'(i) < occ_q;
			if (do_access && (OCC_W'(i) <= pos)) begin
				cell_ctl[i].op = OP_TAKE_PREV;
			end else if (rotate && (OCC_W'(i) == last_idx)) begin
				cell_ctl[i].op = OP_TAKE_WRAP;
			end else if (rotate && (OCC_W'(i) < last_idx)) begin
				cell_ctl[i].op = OP_TAKE_NEXT;
			end else begin
				cell_ctl[i].op = OP_HOLD;
			end
		end

		lkt_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.prev_key (prev_k),
			.next_key (next_k),
			.wrap_key (cell_key[0]),
			.probe    (req.key),
			.key      (cell_key[i]),
			.match    (match[i])
		);
	end

	// --- next result ------------------------------------------------------
	always_comb begin
		rsp_d = '0;
		emit  = 1'b0;
		if (do_access) begin
			emit               = 1'b1;
			rsp_d.hit          = hit;
			rsp_d.evicted_valid = !hit && full;
			rsp_d.evicted_key  = (!hit && full) ? tail_key : '0;
			rsp_d.last         = 1'b1;
		end else if (do_dump) begin
			emit              = 1'b1;
			rsp_d.entry_valid = occ_q != '0;
			rsp_d.entry_key   = (occ_q != '0) ? cell_key[0] : '0;
			rsp_d.last        = occ_q <= OCC_W'(1);
		end else if (dump_step) begin
			emit              = 1'b1;
			rsp_d.entry_valid = 1'b1;
			rsp_d.entry_key   = cell_key[0];
			rsp_d.last        = remain_q == OCC_W'(1);
		end
	end

	// payload register: load with each emitted result
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	// control state, occupancy, capacity and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			remain_q    <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// a miss that does not evict grows the list
			if (do_access && !hit && !full) begin
				occ_q <= occ_q + OCC_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (do_dump && (occ_q > OCC_W'(1))) begin
						state_q  <= ST_DUMP;
						remain_q <= last_idx;
					end
				end
				ST_DUMP: begin
					if (dump_step) begin
						remain_q <= remain_q - OCC_W'(1);
						if (remain_q == OCC_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
